// ----- rtl/core/list_mode_event_deframer_assert.svh -----
// assertion macros shared by the deframer rtl
// each macro checks on the rising clock edge, quiet while reset is low
`ifndef LIST_MODE_EVENT_DEFRAMER_ASSERT_SVH
`define LIST_MODE_EVENT_DEFRAMER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LMED_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LMED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lmed_pkg.sv -----
// ----------------------------------------------------------------------------
// lmed_pkg
// types and constants of the list-mode event deframer
// ----------------------------------------------------------------------------
package lmed_pkg;

    localparam int WORD_W  = 32;
    localparam int MOD_W   = 4;
    localparam int POS_W   = 13;
    localparam int HLEN_W  = 5;
    localparam int STAMP_W = 48;

    localparam logic [31:0] ELEN_MASK  = 32'h3FFE_0000;
    localparam logic [31:0] HLEN_MASK  = 32'h0001_F000;
    localparam logic [31:0] W0_KEEP    = 32'h8001_FFFF;
    localparam logic [31:0] LOW16      = 32'h0000_FFFF;
    localparam int          ELEN_SHIFT = 17;
    localparam int          HLEN_SHIFT = 12;

    // header positions with special meaning
    localparam logic [POS_W-1:0]  POS_START   = 13'd0;
    localparam logic [POS_W-1:0]  POS_TIME_LO = 13'd1;
    localparam logic [POS_W-1:0]  POS_TIME_HI = 13'd2;
    localparam logic [POS_W-1:0]  POS_TRACE   = 13'd3;
    localparam logic [HLEN_W-1:0] HLEN_MIN    = 5'd4;

    // per-module framing context, one memory entry
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   elen;
        logic [HLEN_W-1:0]  hlen;
        logic [STAMP_W-1:0] stamp;
    } ctx_t;

    localparam int CTX_W = $bits(ctx_t);

    // outcome of one word against its context
    typedef struct packed {
        logic               emit;
        logic               write;
        ctx_t               ctx;
        logic [WORD_W-1:0]  word;
        logic [HLEN_W-1:0]  index;
        logic               last;
        logic [STAMP_W-1:0] stamp;
        logic               error;
    } upd_t;

endpackage

// ----- rtl/core/lmed_if.sv -----
// ----------------------------------------------------------------------------
// lmed_if
// valid/ready channels of the deframer: raw words in, header words out
// ----------------------------------------------------------------------------
interface lmed_in_if;
    logic                       valid;
    logic                       ready;
    logic [lmed_pkg::MOD_W-1:0]  module_req;
    logic [lmed_pkg::WORD_W-1:0] data_word;

    modport source (output valid, output module_req, output data_word, input ready);
    modport sink   (input valid, input module_req, input data_word, output ready);
endinterface

interface lmed_out_if;
    logic                        valid;
    logic                        ready;
    logic [lmed_pkg::MOD_W-1:0]   src_module;
    logic [lmed_pkg::WORD_W-1:0]  header_word;
    logic [lmed_pkg::HLEN_W-1:0]  word_index;
    logic                        event_last;
    logic [lmed_pkg::STAMP_W-1:0] event_time;
    logic                        format_error;

    modport source (output valid, output src_module, output header_word, output word_index,
                    output event_last, output event_time, output format_error, input ready);
    modport sink   (input valid, input src_module, input header_word, input word_index,
                    input event_last, input event_time, input format_error, output ready);
endinterface

// ----- rtl/core/list_mode_event_deframer.sv -----
// ----------------------------------------------------------------------------
// list_mode_event_deframer
// per-module list-mode event framing: passes header words, drops trace words
// ----------------------------------------------------------------------------
//  channel    dir  payload
//  events_in  in   module_req, data_word
//  words_out  out  src_module, header_word, word_index, event_last,
//                  event_time, format_error
//
// one word per cycle sustained while the output is not stalled; an accepted word
// is registered with its context ram read, then framed into the output register
// the context ram is read-modify-write; the last write is forwarded
// entries read as zero until first written, tracked by flip-flop valid bits
// a stalled output holds the framing stage, which in turn holds the input
// ----------------------------------------------------------------------------
`include "list_mode_event_deframer_assert.svh"

module list_mode_event_deframer #(
    parameter int MODULE_COUNT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lmed_in_if.sink    events_in,
    lmed_out_if.source words_out
);

    localparam int ADDR_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

    // read stage
    logic                           s1_valid_reg;
    logic                           s1_inrange_reg;
    logic [lmed_pkg::MOD_W-1:0]     s1_mod_reg;
    logic [lmed_pkg::WORD_W-1:0]    s1_word_reg;

    // last ram write, forwarded to the read stage
    logic                           fwd_valid_reg;
    logic [ADDR_W-1:0]              fwd_addr_reg;
    lmed_pkg::ctx_t                 fwd_ctx_reg;
    logic [MODULE_COUNT-1:0]        written_reg;

    // output register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [lmed_pkg::MOD_W-1:0]     out_mod_reg;
    logic [lmed_pkg::WORD_W-1:0]    out_word_reg;
    logic [lmed_pkg::HLEN_W-1:0]    out_index_reg;
    logic                           out_last_reg;
    logic [lmed_pkg::STAMP_W-1:0]   out_time_reg;
    logic                           out_error_reg;

    logic                           in_accept;
    logic                           s1_go;
    logic [5:0]                     in_mod_ext;
    logic [5:0]                     s1_mod_ext;
    logic                           in_inrange;
    logic [ADDR_W-1:0]              in_addr;
    logic [ADDR_W-1:0]              s1_addr;
    logic [lmed_pkg::CTX_W-1:0]     rd_data;
    lmed_pkg::ctx_t                 ctx_cur;
    lmed_pkg::upd_t                 upd;
    logic                           wr_en;

    assign in_mod_ext = {2'b00, events_in.module_req};
    assign s1_mod_ext = {2'b00, s1_mod_reg};
    assign in_inrange = (in_mod_ext < 6'(MODULE_COUNT));
    assign in_addr    = in_mod_ext[ADDR_W-1:0];
    assign s1_addr    = s1_mod_ext[ADDR_W-1:0];

    assign s1_go           = s1_valid_reg && (!out_valid_reg || words_out.ready);
    assign events_in.ready = !s1_valid_reg || s1_go;
    assign in_accept       = events_in.valid && events_in.ready;

    lmed_ram #(
        .WIDTH (lmed_pkg::CTX_W),
        .DEPTH (MODULE_COUNT)
    ) u_ctx_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (upd.ctx),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    // newest context: forwarded write, then ram, then reset value
    always_comb
    begin
        priority if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            ctx_cur = fwd_ctx_reg;
        end
        else if (written_reg[s1_addr])
        begin
            ctx_cur = lmed_pkg::ctx_t'(rd_data);
        end
        else
        begin
            ctx_cur = '0;
        end
    end

    lmed_ctx_update u_update (
        .ctx  (ctx_cur),
        .word (s1_word_reg),
        .upd  (upd)
    );

    assign wr_en = s1_go && s1_inrange_reg && upd.write;

    always_comb
    begin
        if (s1_go)
        begin
            out_valid_next = s1_inrange_reg && upd.emit;
        end
        else if (words_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (events_in.ready)
            begin
                s1_valid_reg <= events_in.valid;
            end
            if (wr_en)
            begin
                fwd_valid_reg        <= 1'b1;
                written_reg[s1_addr] <= 1'b1;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_inrange_reg <= in_inrange;
            s1_mod_reg     <= events_in.module_req;
            s1_word_reg    <= events_in.data_word;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_ctx_reg  <= upd.ctx;
        end
        if (s1_go)
        begin
            out_mod_reg   <= s1_mod_reg;
            out_word_reg  <= upd.word;
            out_index_reg <= upd.index;
            out_last_reg  <= upd.last;
            out_time_reg  <= upd.stamp;
            out_error_reg <= upd.error;
        end
    end

    assign words_out.valid        = out_valid_reg;
    assign words_out.src_module   = out_mod_reg;
    assign words_out.header_word  = out_word_reg;
    assign words_out.word_index   = out_index_reg;
    assign words_out.event_last   = out_last_reg;
    assign words_out.event_time   = out_time_reg;
    assign words_out.format_error = out_error_reg;

    `LMED_ASSERT_SAME(a_error_clean, words_out.valid && words_out.format_error,
        (words_out.header_word == '0) && !words_out.event_last
            && (words_out.word_index == '0) && (words_out.event_time == '0),
        "format error transaction carries header data")
    `LMED_ASSERT_SAME(a_last_index, words_out.valid && words_out.event_last,
        words_out.word_index >= 5'd3,
        "event end flagged before the timestamp words")
    `LMED_ASSERT_SAME(a_ready_cause, !events_in.ready,
        s1_valid_reg && out_valid_reg && !words_out.ready,
        "input stalled without a blocked output")
    `LMED_ASSERT_NEXT(a_fwd_track, wr_en,
        fwd_valid_reg && (fwd_addr_reg == $past(s1_addr)),
        "forwarding register missed a context write")

endmodule

// ----- rtl/core/lmed_ram.sv -----
// ----------------------------------------------------------------------------
// lmed_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lmed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lmed_ctx_update.sv -----
// ----------------------------------------------------------------------------
// lmed_ctx_update
// framing step: applies one word to its module context
// ----------------------------------------------------------------------------
module lmed_ctx_update (
    input  lmed_pkg::ctx_t              ctx,
    input  logic [lmed_pkg::WORD_W-1:0] word,
    output lmed_pkg::upd_t              upd
);

    logic [lmed_pkg::POS_W-1:0]   w_elen;
    logic [lmed_pkg::HLEN_W-1:0]  w_hlen;
    logic [lmed_pkg::POS_W-1:0]   hlen_ext;
    logic [lmed_pkg::POS_W-1:0]   w_hlen_ext;
    logic [lmed_pkg::POS_W-1:0]   pos_inc;
    logic [lmed_pkg::STAMP_W-1:0] stamp_new;
    logic                         trace;

    always_comb
    begin
        w_elen     = lmed_pkg::POS_W'((word & lmed_pkg::ELEN_MASK) >> lmed_pkg::ELEN_SHIFT);
        w_hlen     = lmed_pkg::HLEN_W'((word & lmed_pkg::HLEN_MASK) >> lmed_pkg::HLEN_SHIFT);
        w_hlen_ext = {8'b0, w_hlen};
        hlen_ext   = {8'b0, ctx.hlen};
        pos_inc    = ctx.pos + 13'd1;
        trace      = (ctx.elen != hlen_ext);

        stamp_new = ctx.stamp;
        if (ctx.pos == lmed_pkg::POS_TIME_LO)
        begin
            stamp_new = {16'b0, word};
        end
        else if (ctx.pos == lmed_pkg::POS_TIME_HI)
        begin
            stamp_new = {word[15:0], ctx.stamp[31:0]};
        end

        upd = '0;
        if (ctx.pos == lmed_pkg::POS_START)
        begin
            upd.emit = 1'b1;
            if ((w_hlen < lmed_pkg::HLEN_MIN) || (w_hlen_ext > w_elen))
            begin
                // impossible lengths: flag and stay at event start
                upd.error = 1'b1;
            end
            else
            begin
                upd.write     = 1'b1;
                upd.ctx.pos   = 13'd1;
                upd.ctx.elen  = w_elen;
                upd.ctx.hlen  = w_hlen;
                upd.ctx.stamp = '0;
                if (w_elen != w_hlen_ext)
                begin
                    upd.word = ({27'b0, w_hlen} << lmed_pkg::ELEN_SHIFT)
                             | (word & lmed_pkg::W0_KEEP);
                end
                else
                begin
                    upd.word = word;
                end
            end
        end
        else
        begin
            upd.write     = 1'b1;
            upd.ctx.elen  = ctx.elen;
            upd.ctx.hlen  = ctx.hlen;
            upd.ctx.stamp = stamp_new;
            upd.ctx.pos   = (pos_inc >= ctx.elen) ? lmed_pkg::POS_START : pos_inc;
            // trace words past the header produce nothing
            if (ctx.pos < hlen_ext)
            begin
                upd.emit  = 1'b1;
                upd.index = ctx.pos[lmed_pkg::HLEN_W-1:0];
                upd.last  = (pos_inc == hlen_ext);
                upd.stamp = upd.last ? stamp_new : '0;
                if ((ctx.pos == lmed_pkg::POS_TRACE) && trace)
                begin
                    upd.word = word & lmed_pkg::LOW16;
                end
                else
                begin
                    upd.word = word;
                end
            end
        end
    end

endmodule
